[hw/rtl/hmm_forward_filter_step_unit_macros.svh]
`ifndef HMM_FORWARD_FILTER_STEP_UNIT_MACROS_SVH
`define HMM_FORWARD_FILTER_STEP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HMM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hmm check failed");
`define HMM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hmm check failed");
`else
`define HMM_ASSERT_IMP(name, clk, rst, ante, cons)
`define HMM_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/hmm_fwd_pkg.sv]
package hmm_fwd_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [31:0] transition_weight;
    logic [31:0] initial_prob;
    logic [2:0]  state_index;
    logic [31:0] likelihood;
    logic        last_likelihood;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_state;
    logic [31:0]        filtered_prob;
    logic signed [31:0] log_likelihood;
    logic               zero_total;
    logic               last_state;
  } result_t;

  localparam logic [1:0] OP_TRANS = 2'd0;
  localparam logic [1:0] OP_INIT  = 2'd1;
  localparam logic [1:0] OP_LIK   = 2'd2;

  localparam logic       REG_NUM_STATES     = 1'b0;
  localparam logic [3:0] NUM_STATES_RESET   = 4'd2;
  localparam logic [31:0] ONE_Q31           = 32'h8000_0000;
  localparam logic [31:0] LOG_MIN           = 32'h8000_0000;
  localparam logic [31:0] LN2_Q32           = 32'd2977044472;
  localparam logic [63:0] LN_ROUND          = 64'h0000_0080_0000_0000;
  localparam logic [4:0] SQ_LAST            = 5'd23;
  localparam logic [4:0] DIV_LAST           = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_WMUL, ST_WACC, ST_CHECK, ST_NORM,
    ST_SQ_MUL, ST_SQ_CHK, ST_LN_MUL, ST_LN_FIN, ST_DIV, ST_DIV_DONE, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ITEM, CMD_MAC_MUL, CMD_MAC_ACC, CMD_W_MUL, CMD_W_ACC,
    CMD_ZERO, CMD_NORM_INIT, CMD_NORM_STEP, CMD_SQ_MUL, CMD_SQ_CHK,
    CMD_LN_MUL, CMD_LN_FIN, CMD_DIV_STEP, CMD_DIV_DONE, CMD_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   first;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic norm_done;
    logic out_free;
  } dp_status_t;

endpackage

[hw/rtl/hmm_fwd_ram.sv]
module hmm_fwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/hmm_fwd_datapath.sv]
module hmm_fwd_datapath #(
  parameter int MAX_STATES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hmm_fwd_pkg::item_t            item,
  input  hmm_fwd_pkg::dp_cmd_t          cmd,
  input  logic [$clog2(MAX_STATES)-1:0] i,
  input  logic [$clog2(MAX_STATES)-1:0] j,
  output hmm_fwd_pkg::dp_status_t       stat,
  output logic                          result_valid,
  input  logic                          result_ready,
  output hmm_fwd_pkg::result_t          result
);
  import hmm_fwd_pkg::*;

  localparam int IW = $clog2(MAX_STATES);
  localparam int AW = $clog2(MAX_STATES * MAX_STATES);

  logic [31:0] prob [MAX_STATES];
  logic [31:0] lik [MAX_STATES];
  logic [47:0] weighted [MAX_STATES];
  logic [39:0] acc;
  logic [63:0] prod;
  logic [47:0] total;
  logic [47:0] x48;
  logic [5:0]  n;
  logic [31:0] x;
  logic [23:0] frac;
  logic        neg;
  logic [48:0] rem;
  logic [31:0] q;
  logic [31:0] log_val;
  logic        zero;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [IW-1:0] prob_addr;
  logic [31:0]   prob_rd;
  logic [31:0]   pred_sat;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [31:0]   v_bits;
  logic [31:0]   mag;
  logic [47:0]   w_sat;
  logic [48:0]   tsum;
  logic [32:0]   sq;
  logic [63:0]   rsum;
  logic [48:0]   div_r;
  logic          div_ge;
  logic          item_row_ok;
  logic          item_st_ok;

  assign item_row_ok = (int'(item.row_index) < MAX_STATES) &&
                       (int'(item.col_index) < MAX_STATES);
  assign item_st_ok  = int'(item.state_index) < MAX_STATES;

  assign ram_we    = (cmd.op == CMD_ITEM) && (item.opcode == OP_TRANS) && item_row_ok;
  assign ram_waddr = AW'(int'(item.row_index) * MAX_STATES + int'(item.col_index));
  assign ram_raddr = AW'(int'(i) * MAX_STATES + int'(j));

  hmm_fwd_ram #(.WIDTH(32), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.transition_weight),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign prob_addr = (cmd.op == CMD_MAC_MUL) ? j : i;
  assign prob_rd   = prob[prob_addr];
  assign pred_sat  = (acc[39:32] != '0) ? '1 : acc[31:0];
  assign v_bits    = ((32'(n) - 32'd32) << 24) + 32'(frac);
  assign mag       = v_bits[31] ? (32'd0 - v_bits) : v_bits;
  assign w_sat     = prod[63] ? '1 : prod[62:15];
  assign tsum      = {1'b0, total} + {1'b0, w_sat};
  assign sq        = prod[63:31];
  assign rsum      = prod + LN_ROUND;
  assign div_r     = cmd.first ? {1'b0, weighted[i]} : {rem[47:0], 1'b0};
  assign div_ge    = div_r >= {1'b0, total};

  always_comb begin
    unique case (cmd.op)
      CMD_MAC_MUL: begin
        mul_a = ram_rdata;
        mul_b = prob_rd;
      end
      CMD_W_MUL: begin
        mul_a = lik[i];
        mul_b = pred_sat;
      end
      CMD_SQ_MUL: begin
        mul_a = x;
        mul_b = x;
      end
      default: begin
        mul_a = mag;
        mul_b = LN2_Q32;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MAX_STATES; s++) begin
        prob[s] <= '0;
      end
      result_valid <= 1'b0;
    end else begin
      if (cmd.op == CMD_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (cmd.op)
        CMD_ITEM: begin
          if (item.opcode == OP_INIT && item_st_ok) begin
            prob[IW'(item.state_index)] <= item.initial_prob;
          end
        end
        CMD_ZERO:     prob[0] <= ONE_Q31;
        CMD_DIV_DONE: prob[i] <= q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_ITEM: begin
        if (item.opcode == OP_LIK) begin
          if (item_st_ok) begin
            lik[IW'(item.state_index)] <= item.likelihood;
          end
          total <= '0;
          acc   <= '0;
        end
      end
      CMD_MAC_MUL, CMD_W_MUL, CMD_SQ_MUL: prod <= 64'(mul_a) * 64'(mul_b);
      CMD_MAC_ACC: acc <= acc + 40'(prod[63:31]);
      CMD_W_ACC: begin
        weighted[i] <= w_sat;
        total       <= tsum[48] ? '1 : tsum[47:0];
        acc         <= '0;
      end
      CMD_ZERO: begin
        log_val <= LOG_MIN;
        zero    <= 1'b1;
      end
      CMD_NORM_INIT: begin
        x48  <= total;
        n    <= 6'd47;
        frac <= '0;
      end
      CMD_NORM_STEP: begin
        if (x48[47] || n == '0) begin
          x <= x48[47:16];
        end else begin
          x48 <= {x48[46:0], 1'b0};
          n   <= n - 6'd1;
        end
      end
      CMD_SQ_CHK: begin
        if (sq[32]) begin
          x    <= sq[32:1];
          frac <= {frac[22:0], 1'b1};
        end else begin
          x    <= sq[31:0];
          frac <= {frac[22:0], 1'b0};
        end
      end
      CMD_LN_MUL: begin
        prod <= 64'(mul_a) * 64'(mul_b);
        neg  <= v_bits[31];
      end
      CMD_LN_FIN: begin
        log_val <= neg ? (32'd0 - 32'(rsum[63:40])) : 32'(rsum[63:40]);
        zero    <= 1'b0;
      end
      CMD_DIV_STEP: begin
        rem <= div_ge ? (div_r - {1'b0, total}) : div_r;
        q   <= {(cmd.first ? 31'd0 : q[30:0]), div_ge};
      end
      CMD_EMIT: begin
        result.out_state      <= 3'(i);
        result.filtered_prob  <= prob_rd;
        result.log_likelihood <= log_val;
        result.zero_total     <= zero;
        result.last_state     <= cmd.last;
      end
      default: ;
    endcase
  end

  assign stat.total_zero = total == '0;
  assign stat.norm_done  = x48[47] || n == '0;
  assign stat.out_free   = !result_valid || result_ready;

endmodule

[hw/rtl/hmm_fwd_ctrl.sv]
module hmm_fwd_ctrl #(
  parameter int MAX_STATES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_STATES+1)-1:0] k,
  input  logic                            item_valid,
  input  logic [1:0]                      item_opcode,
  input  logic                            item_last,
  output logic                            item_ready,
  input  hmm_fwd_pkg::dp_status_t         stat,
  output hmm_fwd_pkg::dp_cmd_t            cmd,
  output logic [$clog2(MAX_STATES)-1:0]   i,
  output logic [$clog2(MAX_STATES)-1:0]   j
);
  import hmm_fwd_pkg::*;

  localparam int IW = $clog2(MAX_STATES);
  localparam int KW = $clog2(MAX_STATES + 1);

  ctrl_state_t   state, state_next;
  logic [IW-1:0] i_next, j_next;
  logic [4:0]    cnt, cnt_next;
  logic [IW-1:0] k_last;
  logic          i_last, j_last;

  assign k_last = IW'(k - KW'(1));
  assign i_last = i == k_last;
  assign j_last = j == k_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    cnt_next   = cnt;
    item_ready = 1'b0;
    cmd.op     = CMD_NONE;
    cmd.first  = 1'b0;
    cmd.last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.op = CMD_ITEM;
          if (item_opcode == OP_LIK && item_last) begin
            i_next     = '0;
            j_next     = '0;
            state_next = ST_RD;
          end
        end
      end
      ST_RD: state_next = ST_MUL;
      ST_MUL: begin
        cmd.op     = CMD_MAC_MUL;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = CMD_MAC_ACC;
        if (j_last) begin
          state_next = ST_WMUL;
        end else begin
          j_next     = j + IW'(1);
          state_next = ST_RD;
        end
      end
      ST_WMUL: begin
        cmd.op     = CMD_W_MUL;
        state_next = ST_WACC;
      end
      ST_WACC: begin
        cmd.op = CMD_W_ACC;
        j_next = '0;
        if (i_last) begin
          state_next = ST_CHECK;
        end else begin
          i_next     = i + IW'(1);
          state_next = ST_RD;
        end
      end
      ST_CHECK: begin
        i_next = '0;
        if (stat.total_zero) begin
          cmd.op     = CMD_ZERO;
          state_next = ST_EMIT;
        end else begin
          cmd.op     = CMD_NORM_INIT;
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.op = CMD_NORM_STEP;
        if (stat.norm_done) begin
          cnt_next   = '0;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        cmd.op     = CMD_SQ_MUL;
        state_next = ST_SQ_CHK;
      end
      ST_SQ_CHK: begin
        cmd.op = CMD_SQ_CHK;
        if (cnt == SQ_LAST) begin
          state_next = ST_LN_MUL;
        end else begin
          cnt_next   = cnt + 5'd1;
          state_next = ST_SQ_MUL;
        end
      end
      ST_LN_MUL: begin
        cmd.op     = CMD_LN_MUL;
        state_next = ST_LN_FIN;
      end
      ST_LN_FIN: begin
        cmd.op     = CMD_LN_FIN;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op    = CMD_DIV_STEP;
        cmd.first = cnt == '0;
        cnt_next  = cnt + 5'd1;
        if (cnt == DIV_LAST) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        cmd.op     = CMD_DIV_DONE;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op   = CMD_EMIT;
          cmd.last = i_last;
          if (i_last) begin
            state_next = ST_IDLE;
          end else begin
            i_next   = i + IW'(1);
            cnt_next = '0;
            if (!stat.total_zero) begin
              state_next = ST_DIV;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/hmm_forward_filter_step_unit.sv]
// items: write items are taken while idle; a final likelihood starts a step,
// and item_ready stays low until its last result is issued (k states in use)
// one step at a time; a step uses the shared 32x32 multiplier, the normalizer,
// 24 squaring rounds and a divide per state
// reset: synchronous active-high rst; num_states returns to 2, probabilities to 0
`include "hmm_forward_filter_step_unit_macros.svh"
module hmm_forward_filter_step_unit #(
  parameter int MAX_STATES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  hmm_fwd_pkg::item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output hmm_fwd_pkg::result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hmm_fwd_pkg::*;

  localparam int IW = $clog2(MAX_STATES);
  localparam int KW = $clog2(MAX_STATES + 1);

  logic [3:0]    num_states;
  logic [KW-1:0] k;
  dp_cmd_t       cmd;
  dp_status_t    stat;
  logic [IW-1:0] i, j;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_STATES) ? {28'd0, num_states} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= NUM_STATES_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_NUM_STATES) begin
      num_states <= pwdata[3:0];
    end
  end

  always_comb begin
    priority if (num_states == '0) begin
      k = KW'(1);
    end else if (int'(num_states) > MAX_STATES) begin
      k = KW'(MAX_STATES);
    end else begin
      k = KW'(num_states);
    end
  end

  hmm_fwd_ctrl #(.MAX_STATES(MAX_STATES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .k           (k),
    .item_valid  (item_valid),
    .item_opcode (item.opcode),
    .item_last   (item.last_likelihood),
    .item_ready  (item_ready),
    .stat        (stat),
    .cmd         (cmd),
    .i           (i),
    .j           (j)
  );

  hmm_fwd_datapath #(.MAX_STATES(MAX_STATES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .i            (i),
    .j            (j),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a pending non-final result means the step is still running
  `HMM_ASSERT_IMP(a_busy_mid_step, clk, rst, result_valid && !result.last_state, !item_ready)
  // a final likelihood transfer starts the step
  `HMM_ASSERT_NXT(a_step_starts, clk, rst, item_valid && item_ready && item.opcode == OP_LIK && item.last_likelihood, !item_ready)
  // zero sum always carries the saturated log
  `HMM_ASSERT_IMP(a_zero_log, clk, rst, result_valid && result.zero_total, result.log_likelihood == LOG_MIN)

endmodule
